>>> rtl/usd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// usd_pkg
// Shared types, constants and decode helpers for the Unicode stream decoder.
// ----------------------------------------------------------------------------
package usd_pkg;

    localparam int OFFSET_BITS_DEF = 32;
    localparam int OUT_OFF_BITS    = 32;

    localparam logic [2:0] MODE_UTF8    = 3'd0;
    localparam logic [2:0] MODE_UTF16LE = 3'd1;
    localparam logic [2:0] MODE_UTF16BE = 3'd2;
    localparam logic [2:0] MODE_UTF32LE = 3'd3;
    localparam logic [2:0] MODE_UTF32BE = 3'd4;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_TRUNC     = 3'd1;
    localparam logic [2:0] ERR_BAD_CONT  = 3'd2;
    localparam logic [2:0] ERR_OVERLONG  = 3'd3;
    localparam logic [2:0] ERR_RANGE     = 3'd4;
    localparam logic [2:0] ERR_BAD_BYTE  = 3'd5;
    localparam logic [2:0] ERR_LONE_SURR = 3'd6;

    localparam logic [20:0] REPL_CP = 21'h00FFFD;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_beat;

    typedef struct packed {
        logic [20:0]             code_point;
        logic                    has_code_point;
        logic [2:0]              error_reason;
        logic [OUT_OFF_BITS-1:0] error_offset;
        logic                    run_end;
        logic                    buffer_end;
    } t_out_beat;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_EMIT,
        ST_TAIL
    } t_state;

    // Controller -> datapath
    typedef struct packed {
        logic load;   // capture input beat into window
        logic step;   // run one decode step and register a result
        logic tail;   // register the trailing partial-unit result
        logic done;   // commit leftover bytes and advance position
    } t_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic more;     // window holds a decodable unit or error
        logic need_tail;
    } t_status;

    // One decode step over a window of up to four bytes.
    typedef struct packed {
        logic        emit;
        logic [20:0] cp;
        logic [2:0]  reason;
        logic [2:0]  adv;
    } t_step;

    function automatic t_step decode_step(
        input logic [2:0] mode, input logic [31:0] w, input logic [2:0] n,
        input logic last);
        t_step       s;
        logic [7:0]  b0, b1, b2, b3;
        logic [2:0]  len;
        logic        badc;
        logic [20:0] cp;
        logic [15:0] u, lo;
        logic [31:0] c32;
        s = '0;
        b0 = w[31:24]; b1 = w[23:16]; b2 = w[15:8]; b3 = w[7:0];
        len = 3'd0; badc = 1'b0; cp = '0;
        u = '0; lo = '0; c32 = '0;
        case (mode)
            MODE_UTF8: begin
                if (n != 3'd0) begin
                    if (b0 < 8'h80) begin
                        s.emit = 1'b1; s.cp = {13'd0, b0}; s.adv = 3'd1;
                    end else begin
                        if ((b0 & 8'hE0) == 8'hC0) len = 3'd2;
                        else if ((b0 & 8'hF0) == 8'hE0) len = 3'd3;
                        else if ((b0 & 8'hF8) == 8'hF0) len = 3'd4;
                        if (len == 3'd0) begin
                            s.emit = 1'b1; s.cp = REPL_CP; s.reason = ERR_BAD_BYTE;
                            s.adv = 3'd1;
                        end else if (len > n) begin
                            if (last) begin
                                s.emit = 1'b1; s.cp = REPL_CP; s.reason = ERR_TRUNC;
                                s.adv = 3'd1;
                            end
                        end else begin
                            if ((b1 & 8'hC0) != 8'h80) badc = 1'b1;
                            if (len >= 3'd3 && (b2 & 8'hC0) != 8'h80) badc = 1'b1;
                            if (len == 3'd4 && (b3 & 8'hC0) != 8'h80) badc = 1'b1;
                            s.emit = 1'b1;
                            s.adv = 3'd1;
                            s.cp = REPL_CP;
                            if (badc) begin
                                s.reason = ERR_BAD_CONT;
                            end else if (len == 3'd2) begin
                                cp = {10'd0, b0[4:0], b1[5:0]};
                                if (cp < 21'h80) s.reason = ERR_OVERLONG;
                                else begin s.cp = cp; s.adv = 3'd2; end
                            end else if (len == 3'd3) begin
                                cp = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
                                if (cp < 21'h800 || (cp >= 21'hD800 && cp <= 21'hDFFF))
                                    s.reason = ERR_OVERLONG;
                                else begin s.cp = cp; s.adv = 3'd3; end
                            end else begin
                                cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
                                if (cp < 21'h10000 || cp > 21'h10FFFF)
                                    s.reason = ERR_RANGE;
                                else begin s.cp = cp; s.adv = 3'd4; end
                            end
                        end
                    end
                end
            end
            MODE_UTF16LE, MODE_UTF16BE: begin
                if (mode == MODE_UTF16BE) begin
                    u = {b0, b1}; lo = {b2, b3};
                end else begin
                    u = {b1, b0}; lo = {b3, b2};
                end
                if (n >= 3'd2) begin
                    if (u >= 16'hD800 && u <= 16'hDBFF) begin
                        if (n < 3'd4) begin
                            if (last) begin
                                s.emit = 1'b1; s.cp = REPL_CP; s.reason = ERR_TRUNC;
                                s.adv = 3'd2;
                            end
                        end else if (lo < 16'hDC00 || lo > 16'hDFFF) begin
                            s.emit = 1'b1; s.cp = REPL_CP; s.reason = ERR_BAD_CONT;
                            s.adv = 3'd2;
                        end else begin
                            s.emit = 1'b1;
                            s.cp = 21'h10000 + {1'b0, u[9:0], lo[9:0]};
                            s.adv = 3'd4;
                        end
                    end else if (u >= 16'hDC00 && u <= 16'hDFFF) begin
                        s.emit = 1'b1; s.cp = REPL_CP; s.reason = ERR_LONE_SURR;
                        s.adv = 3'd2;
                    end else begin
                        s.emit = 1'b1; s.cp = {5'd0, u}; s.adv = 3'd2;
                    end
                end
            end
            MODE_UTF32LE, MODE_UTF32BE: begin
                if (mode == MODE_UTF32BE) c32 = w;
                else c32 = {b3, b2, b1, b0};
                if (n == 3'd4) begin
                    s.emit = 1'b1; s.adv = 3'd4;
                    if (c32 > 32'h10FFFF || (c32 >= 32'hD800 && c32 <= 32'hDFFF)) begin
                        s.cp = REPL_CP; s.reason = ERR_RANGE;
                    end else begin
                        s.cp = c32[20:0];
                    end
                end
            end
            default: s = '0;
        endcase
        return s;
    endfunction

endpackage
`default_nettype wire

>>> rtl/usd_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// usd_datapath
// Byte window, position counter, decode step and output register.
// ----------------------------------------------------------------------------
module usd_datapath #(
    parameter int OFFSET_BITS = usd_pkg::OFFSET_BITS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [2:0]        i_mode,
    input  wire usd_pkg::t_in_beat i_beat,
    input  wire usd_pkg::t_cmd     i_cmd,
    output usd_pkg::t_status       o_status,
    output usd_pkg::t_out_beat     o_beat
);

    localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;

    logic [31:0]            r_win, n_win;
    logic [2:0]             r_n, n_n;
    logic [OFFSET_BITS-1:0] r_pos, n_pos;
    logic [OFFSET_BITS-1:0] r_base, n_base;
    logic                   r_last, n_last;
    usd_pkg::t_out_beat     r_out, n_out;
    usd_pkg::t_step         w_s;
    logic                   w_known;
    logic [OFFSET_BITS-1:0] w_base_adv;
    logic [31:0]            w_base_sat, w_pos_sat;

    assign w_s     = usd_pkg::decode_step(i_mode, r_win, r_n, r_last);
    assign w_known = (i_mode <= usd_pkg::MODE_UTF32BE);

    function automatic logic [31:0] sat32(input logic [OFFSET_BITS-1:0] v);
        logic [63:0] e;
        e = 64'(v);
        return (e > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : e[31:0];
    endfunction

    assign w_base_sat = sat32(r_base);
    assign w_pos_sat  = sat32(r_pos);
    assign w_base_adv = (r_base > OFF_MAX - OFFSET_BITS'(w_s.adv)) ?
                        OFF_MAX : r_base + OFFSET_BITS'(w_s.adv);

    assign o_status.more      = w_known && w_s.emit;
    assign o_status.need_tail = w_known && (i_mode != usd_pkg::MODE_UTF8) && r_last
                                && (r_n != 3'd0);

    always_comb begin
        n_win  = r_win;
        n_n    = r_n;
        n_pos  = r_pos;
        n_base = r_base;
        n_last = r_last;
        n_out  = r_out;
        if (i_cmd.load) begin
            n_win  = r_win;
            n_win[31 - 8*r_n[1:0] -: 8] = i_beat.data_byte;
            n_n    = r_n + 3'd1;
            n_last = i_beat.last_byte;
            n_base = (r_pos >= OFFSET_BITS'(r_n)) ? r_pos - OFFSET_BITS'(r_n) : '0;
        end
        if (i_cmd.step) begin
            n_out.code_point     = w_s.cp;
            n_out.has_code_point = 1'b1;
            n_out.error_reason   = w_s.reason;
            n_out.error_offset   = (w_s.reason != usd_pkg::ERR_NONE) ? w_base_sat : '0;
            n_out.run_end        = 1'b0;
            n_out.buffer_end     = 1'b0;
            n_win  = r_win << (8 * w_s.adv);
            n_n    = r_n - w_s.adv;
            n_base = w_base_adv;
        end
        if (i_cmd.tail) begin
            n_out.code_point     = '0;
            n_out.has_code_point = 1'b0;
            n_out.error_reason   = usd_pkg::ERR_TRUNC;
            n_out.error_offset   = w_pos_sat;
            n_out.run_end        = 1'b0;
            n_out.buffer_end     = 1'b0;
        end
        if (i_cmd.done) begin
            if (r_last || !w_known) n_n = 3'd0;
            if (r_last) n_pos = '0;
            else if (r_pos != OFF_MAX) n_pos = r_pos + OFFSET_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n   <= '0;
            r_pos <= '0;
        end else begin
            r_n   <= n_n;
            r_pos <= n_pos;
        end
        r_win  <= n_win;
        r_base <= n_base;
        r_last <= n_last;
        r_out  <= n_out;
    end

    assign o_beat = r_out;

    property p_window_bound;
        @(posedge i_clk) disable iff (!i_rst_n) r_n <= 3'd4;
    endproperty
    a_window_bound: assert property (p_window_bound) else $error("window overflow");

    property p_pos_clear;
        @(posedge i_clk) disable iff (!i_rst_n) (i_cmd.done && r_last) |=> (r_pos == '0);
    endproperty
    a_pos_clear: assert property (p_pos_clear) else $error("position not cleared");

    property p_err_offset;
        @(posedge i_clk) disable iff (!i_rst_n)
            (i_cmd.step && w_s.reason == usd_pkg::ERR_NONE) |=> (r_out.error_offset == '0);
    endproperty
    a_err_offset: assert property (p_err_offset) else $error("offset on clean result");

endmodule
`default_nettype wire

>>> rtl/usd_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// usd_ctrl
// Sequencer: load a beat, step the decoder, hand each result to the output.
// ----------------------------------------------------------------------------
module usd_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    input  wire logic            i_out_stall,
    input  wire usd_pkg::t_status i_status,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    output logic                 o_run_end,
    output logic                 o_cfg_ready,
    output usd_pkg::t_cmd        o_cmd
);

    usd_pkg::t_state r_state, n_state;
    logic            r_tail_out, n_tail_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= usd_pkg::ST_IDLE;
            r_tail_out <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_tail_out <= n_tail_out;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_tail_out  = r_tail_out;
        o_cmd       = '0;
        o_in_stall  = 1'b1;
        o_out_valid = 1'b0;
        o_run_end   = 1'b0;
        o_cfg_ready = 1'b0;
        case (r_state)
            usd_pkg::ST_IDLE: begin
                o_in_stall  = 1'b0;
                o_cfg_ready = !i_in_valid;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = usd_pkg::ST_DECODE;
                end
            end
            usd_pkg::ST_DECODE: begin
                if (i_status.more) begin
                    o_cmd.step = 1'b1;
                    n_tail_out = 1'b0;
                    n_state    = usd_pkg::ST_EMIT;
                end else if (i_status.need_tail) begin
                    o_cmd.tail = 1'b1;
                    n_tail_out = 1'b1;
                    n_state    = usd_pkg::ST_TAIL;
                end else begin
                    o_cmd.done = 1'b1;
                    n_state    = usd_pkg::ST_IDLE;
                end
            end
            usd_pkg::ST_EMIT: begin
                // result waits; peek whether it closes the run
                o_out_valid = 1'b1;
                o_run_end   = !i_status.more && !i_status.need_tail;
                if (!i_out_stall) begin
                    if (i_status.more) begin
                        o_cmd.step = 1'b1;
                    end else if (i_status.need_tail) begin
                        o_cmd.tail = 1'b1;
                        n_tail_out = 1'b1;
                        n_state    = usd_pkg::ST_TAIL;
                    end else begin
                        o_cmd.done = 1'b1;
                        n_state    = usd_pkg::ST_IDLE;
                    end
                end
            end
            usd_pkg::ST_TAIL: begin
                o_out_valid = 1'b1;
                o_run_end   = 1'b1;
                if (!i_out_stall) begin
                    o_cmd.done = 1'b1;
                    n_tail_out = 1'b0;
                    n_state    = usd_pkg::ST_IDLE;
                end
            end
            default: n_state = usd_pkg::ST_IDLE;
        endcase
    end

    property p_tail_state;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_state == usd_pkg::ST_TAIL) |-> r_tail_out;
    endproperty
    a_tail_state: assert property (p_tail_state) else $error("tail flag lost");

    property p_no_accept_busy;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_state != usd_pkg::ST_IDLE) |-> o_in_stall;
    endproperty
    a_no_accept_busy: assert property (p_no_accept_busy) else $error("accept while busy");

    property p_load_decode;
        @(posedge i_clk) disable iff (!i_rst_n) o_cmd.load |=> (r_state == usd_pkg::ST_DECODE);
    endproperty
    a_load_decode: assert property (p_load_decode) else $error("load without decode");

endmodule
`default_nettype wire

>>> rtl/unicode_stream_decoder_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// unicode_stream_decoder_top
// Byte-serial UTF-8 / UTF-16 / UTF-32 decoder with error replacement.
//
//   channel  | handshake          | beat
//   ---------+--------------------+----------------------------------
//   input    | i_in_valid/o_in_stall   | t_in_beat (data_byte, last_byte)
//   output   | o_out_valid/i_out_stall | t_out_beat (code point, error)
//   config   | i_cfg_valid/o_cfg_ready | encoding_mode, 3 bits
//
// A beat is loaded, then decoded into at most 4 results.
// The result register holds one result; the sequencer steps once per result.
// Output stall holds the sequencer and the result register.
// Synchronous active-low reset clears held count, position and mode.
// ----------------------------------------------------------------------------
module unicode_stream_decoder_top #(
    parameter int OFFSET_BITS = usd_pkg::OFFSET_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire usd_pkg::t_in_beat  i_in_beat,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output usd_pkg::t_out_beat      o_out_beat,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [2:0]         i_cfg_data
);

    logic [2:0]          r_mode;
    usd_pkg::t_cmd       w_cmd;
    usd_pkg::t_status    w_status;
    usd_pkg::t_out_beat  w_beat;
    logic                w_run_end;
    logic                r_last_seen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= usd_pkg::MODE_UTF8;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_mode <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_seen <= 1'b0;
        end else if (w_cmd.load) begin
            r_last_seen <= i_in_beat.last_byte;
        end
    end

    usd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_status    (w_status),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_run_end   (w_run_end),
        .o_cfg_ready (o_cfg_ready),
        .o_cmd       (w_cmd)
    );

    usd_datapath #(.OFFSET_BITS(OFFSET_BITS)) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_mode   (r_mode),
        .i_beat   (i_in_beat),
        .i_cmd    (w_cmd),
        .o_status (w_status),
        .o_beat   (w_beat)
    );

    always_comb begin
        o_out_beat            = w_beat;
        o_out_beat.run_end    = w_run_end;
        o_out_beat.buffer_end = w_run_end && r_last_seen;
    end

endmodule
`default_nettype wire

>>> sim/tb_unicode_stream_decoder_top.sv
// ----------------------------------------------------------------------------
// tb_unicode_stream_decoder_top
// Self-checking bench for the Unicode stream decoder. Byte buffers in every
// encoding mode go through the input channel, and each accepted beat is decoded
// by a local byte-window model. Every result beat is checked field by field
// against the oldest predicted code point. The input channel idles and the
// output channel stalls at random, and the mode register changes between phases.
// ----------------------------------------------------------------------------
module tb_unicode_stream_decoder_top;

    typedef logic [7:0] t_byte_seq[$];

    localparam logic [2:0]  MODE_UNK_LO = 3'd5;
    localparam logic [2:0]  MODE_UNK_HI = 3'd7;
    localparam logic [31:0] POS_MAX     = 32'hFFFF_FFFF;
    localparam int          DRAIN_CYC   = 12;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               o_in_stall;
    usd_pkg::t_in_beat  in_beat = '0;
    logic               o_out_valid;
    logic               out_stall = 1'b0;
    usd_pkg::t_out_beat o_out_beat;
    logic               cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [2:0]         cfg_data = '0;

    unicode_stream_decoder_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_beat   (in_beat),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_beat  (o_out_beat),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    usd_pkg::t_in_beat  pending_bytes[$];
    usd_pkg::t_out_beat expected_cps[$];
    logic [7:0]  held[3];
    int          held_cnt = 0;
    logic [31:0] byte_pos = '0;
    logic [2:0]  cur_mode = usd_pkg::MODE_UTF8;
    bit          burst = 1'b0;
    bit          failed = 1'b0;
    int          in_gap = 0;
    int          stall_left = 0;
    int          sent_items = 0;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic [31:0] off_at(input logic [31:0] base, input int i);
        logic [32:0] sum;
        sum = {1'b0, base} + 33'(i);
        return sum[32] ? POS_MAX : sum[31:0];
    endfunction

    function automatic void add_cp(ref usd_pkg::t_out_beat r[$], input logic [20:0] cp,
                                   input logic has, input logic [2:0] reason,
                                   input logic [31:0] off);
        usd_pkg::t_out_beat o;
        if (r.size() >= 4) return;
        o = '0;
        o.code_point     = cp;
        o.has_code_point = has;
        o.error_reason   = reason;
        o.error_offset   = (reason != usd_pkg::ERR_NONE) ? off : '0;
        r = {r, o};
    endfunction

    function automatic void put_byte(ref t_byte_seq s, input logic [7:0] b);
        s = {s, b};
    endfunction

    task automatic predict_beat(input usd_pkg::t_in_beat b);
        logic [7:0]  w[4];
        int          n, idx, len, h, rem;
        bit          last, badc, stop;
        logic [31:0] base, cur, cp, u, lo;
        usd_pkg::t_out_beat r[$];
        h = held_cnt;
        cur = byte_pos;
        base = (cur >= h) ? cur - h : '0;
        for (int i = 0; i < h; i++) w[i] = held[i];
        w[h] = b.data_byte;
        n = h + 1;
        last = b.last_byte;
        idx = 0;
        stop = 0;
        case (cur_mode)
            usd_pkg::MODE_UTF8: begin
                while (idx < n && !stop) begin
                    if (w[idx] < 8'h80) begin
                        add_cp(r, 21'(w[idx]), 1'b1, usd_pkg::ERR_NONE, '0);
                        idx++;
                        continue;
                    end
                    if ((w[idx] & 8'hE0) == 8'hC0) len = 2;
                    else if ((w[idx] & 8'hF0) == 8'hE0) len = 3;
                    else if ((w[idx] & 8'hF8) == 8'hF0) len = 4;
                    else len = 0;
                    if (len == 0) begin
                        add_cp(r, usd_pkg::REPL_CP, 1'b1, usd_pkg::ERR_BAD_BYTE,
                               off_at(base, idx));
                        idx++;
                    end else if (idx + len > n) begin
                        if (!last) stop = 1;
                        else begin
                            add_cp(r, usd_pkg::REPL_CP, 1'b1, usd_pkg::ERR_TRUNC,
                                   off_at(base, idx));
                            idx++;
                        end
                    end else begin
                        badc = 0;
                        for (int k = 1; k < len; k++)
                            if ((w[idx+k] & 8'hC0) != 8'h80) badc = 1;
                        if (len == 2)
                            cp = {w[idx][4:0], w[idx+1][5:0]};
                        else if (len == 3)
                            cp = {w[idx][3:0], w[idx+1][5:0], w[idx+2][5:0]};
                        else
                            cp = {w[idx][2:0], w[idx+1][5:0], w[idx+2][5:0], w[idx+3][5:0]};
                        if (badc) begin
                            add_cp(r, usd_pkg::REPL_CP, 1'b1, usd_pkg::ERR_BAD_CONT,
                                   off_at(base, idx));
                            idx++;
                        end else if ((len == 2 && cp < 32'h80) ||
                                     (len == 3 && (cp < 32'h800 ||
                                      (cp >= 32'hD800 && cp <= 32'hDFFF)))) begin
                            add_cp(r, usd_pkg::REPL_CP, 1'b1, usd_pkg::ERR_OVERLONG,
                                   off_at(base, idx));
                            idx++;
                        end else if (len == 4 && (cp < 32'h10000 || cp > 32'h10FFFF)) begin
                            add_cp(r, usd_pkg::REPL_CP, 1'b1, usd_pkg::ERR_RANGE,
                                   off_at(base, idx));
                            idx++;
                        end else begin
                            add_cp(r, cp[20:0], 1'b1, usd_pkg::ERR_NONE, '0);
                            idx += len;
                        end
                    end
                end
            end
            usd_pkg::MODE_UTF16LE, usd_pkg::MODE_UTF16BE: begin
                while (idx + 1 < n && !stop) begin
                    u = (cur_mode == usd_pkg::MODE_UTF16BE) ? {w[idx], w[idx+1]}
                                                            : {w[idx+1], w[idx]};
                    if (u >= 32'hD800 && u <= 32'hDBFF) begin
                        if (idx + 3 >= n) begin
                            if (!last) stop = 1;
                            else begin
                                add_cp(r, usd_pkg::REPL_CP, 1'b1, usd_pkg::ERR_TRUNC,
                                       off_at(base, idx));
                                idx += 2;
                            end
                        end else begin
                            lo = (cur_mode == usd_pkg::MODE_UTF16BE) ? {w[idx+2], w[idx+3]}
                                                                     : {w[idx+3], w[idx+2]};
                            if (lo < 32'hDC00 || lo > 32'hDFFF) begin
                                add_cp(r, usd_pkg::REPL_CP, 1'b1, usd_pkg::ERR_BAD_CONT,
                                       off_at(base, idx));
                                idx += 2;
                            end else begin
                                cp = 32'h10000 + (((u - 32'hD800) << 10) | (lo - 32'hDC00));
                                add_cp(r, cp[20:0], 1'b1, usd_pkg::ERR_NONE, '0);
                                idx += 4;
                            end
                        end
                    end else if (u >= 32'hDC00 && u <= 32'hDFFF) begin
                        add_cp(r, usd_pkg::REPL_CP, 1'b1, usd_pkg::ERR_LONE_SURR,
                               off_at(base, idx));
                        idx += 2;
                    end else begin
                        add_cp(r, u[20:0], 1'b1, usd_pkg::ERR_NONE, '0);
                        idx += 2;
                    end
                end
            end
            usd_pkg::MODE_UTF32LE, usd_pkg::MODE_UTF32BE: begin
                while (idx + 3 < n) begin
                    cp = (cur_mode == usd_pkg::MODE_UTF32BE)
                        ? {w[idx], w[idx+1], w[idx+2], w[idx+3]}
                        : {w[idx+3], w[idx+2], w[idx+1], w[idx]};
                    if (cp > 32'h10FFFF || (cp >= 32'hD800 && cp <= 32'hDFFF))
                        add_cp(r, usd_pkg::REPL_CP, 1'b1, usd_pkg::ERR_RANGE,
                               off_at(base, idx));
                    else
                        add_cp(r, cp[20:0], 1'b1, usd_pkg::ERR_NONE, '0);
                    idx += 4;
                end
            end
            default: idx = n;
        endcase
        if (cur_mode >= usd_pkg::MODE_UTF16LE && cur_mode <= usd_pkg::MODE_UTF32BE
            && last && idx < n)
            add_cp(r, '0, 1'b0, usd_pkg::ERR_TRUNC, cur);
        if (last || idx >= n) begin
            held_cnt = 0;
        end else begin
            rem = (n - idx > 3) ? 3 : n - idx;
            for (int i = 0; i < rem; i++) held[i] = w[idx+i];
            held_cnt = rem;
        end
        if (r.size() > 0) begin
            r[r.size()-1].run_end = 1'b1;
            r[r.size()-1].buffer_end = last;
        end
        foreach (r[i]) expected_cps = {expected_cps, r[i]};
        byte_pos = last ? '0 : off_at(cur, 1);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            in_gap <= 0;
        end else begin
            if (in_valid && !o_in_stall) predict_beat(in_beat);
            if (in_valid && o_in_stall) begin
            end else if (in_gap != 0) begin
                in_valid <= 1'b0;
                in_gap <= in_gap - 1;
            end else if (pending_bytes.size() != 0) begin
                in_valid <= 1'b1;
                in_beat <= pending_bytes.pop_front();
                in_gap <= burst ? 0 : $urandom_range(0, 7);
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall <= 1'b0;
            stall_left <= 0;
        end else if (o_out_valid && !out_stall) begin
            if (expected_cps.size() == 0) begin
                $error("unexpected result beat cp=%h", o_out_beat.code_point);
                failed = 1'b1;
            end else begin
                usd_pkg::t_out_beat e;
                e = expected_cps.pop_front();
                if (o_out_beat.code_point !== e.code_point) begin
                    $error("code_point exp %h got %h", e.code_point, o_out_beat.code_point);
                    failed = 1'b1;
                end
                if (o_out_beat.has_code_point !== e.has_code_point) begin
                    $error("has_code_point exp %0d got %0d", e.has_code_point,
                           o_out_beat.has_code_point);
                    failed = 1'b1;
                end
                if (o_out_beat.error_reason !== e.error_reason) begin
                    $error("error_reason exp %0d got %0d", e.error_reason,
                           o_out_beat.error_reason);
                    failed = 1'b1;
                end
                if (o_out_beat.error_offset !== e.error_offset) begin
                    $error("error_offset exp %0d got %0d", e.error_offset,
                           o_out_beat.error_offset);
                    failed = 1'b1;
                end
                if (o_out_beat.run_end !== e.run_end) begin
                    $error("run_end exp %0d got %0d", e.run_end, o_out_beat.run_end);
                    failed = 1'b1;
                end
                if (o_out_beat.buffer_end !== e.buffer_end) begin
                    $error("buffer_end exp %0d got %0d", e.buffer_end,
                           o_out_beat.buffer_end);
                    failed = 1'b1;
                end
            end
            stall_left <= burst ? 0 : $urandom_range(0, 7);
            out_stall <= burst ? 1'b0 : ($urandom_range(0, 1) == 1);
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            out_stall <= (stall_left > 1);
        end else begin
            out_stall <= 1'b0;
        end
    end

    task automatic push_seq(input t_byte_seq s, input bit close);
        usd_pkg::t_in_beat b;
        foreach (s[i]) begin
            b.data_byte = s[i];
            b.last_byte = close && (i == s.size() - 1);
            pending_bytes = {pending_bytes, b};
        end
        sent_items += s.size();
    endtask

    task automatic wait_drain();
        do @(posedge i_clk);
        while (pending_bytes.size() != 0 || in_valid || expected_cps.size() != 0);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic [2:0] m);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data <= m;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        cur_mode = m;
    endtask

    task automatic u_push16(input logic [2:0] m, input logic [31:0] u, ref t_byte_seq s);
        if (u == 32'hFFFF_FFFF) return;
        if (m == usd_pkg::MODE_UTF16BE) begin
            put_byte(s, u[15:8]);
            put_byte(s, u[7:0]);
        end else begin
            put_byte(s, u[7:0]);
            put_byte(s, u[15:8]);
        end
    endtask

    task automatic add_char(input logic [2:0] m, ref t_byte_seq s);
        logic [31:0] cp, hi, lo;
        case ($urandom_range(0, 3))
            0: cp = $urandom_range(0, 32'h7F);
            1: cp = $urandom_range(32'h80, 32'h7FF);
            2: cp = $urandom_range(32'h800, 32'hFFFF);
            default: cp = $urandom_range(32'h10000, 32'h10FFFF);
        endcase
        case (m)
            usd_pkg::MODE_UTF8: begin
                if (cp < 32'h80) put_byte(s, cp[7:0]);
                else if (cp < 32'h800) begin
                    put_byte(s, {3'b110, cp[10:6]});
                    put_byte(s, {2'b10, cp[5:0]});
                end else if (cp < 32'h10000) begin
                    put_byte(s, {4'b1110, cp[15:12]});
                    put_byte(s, {2'b10, cp[11:6]});
                    put_byte(s, {2'b10, cp[5:0]});
                end else begin
                    put_byte(s, {5'b11110, cp[20:18]});
                    put_byte(s, {2'b10, cp[17:12]});
                    put_byte(s, {2'b10, cp[11:6]});
                    put_byte(s, {2'b10, cp[5:0]});
                end
            end
            usd_pkg::MODE_UTF16LE, usd_pkg::MODE_UTF16BE: begin
                if (cp >= 32'h10000) begin
                    hi = 32'hD800 + ((cp - 32'h10000) >> 10);
                    lo = 32'hDC00 + (cp & 32'h3FF);
                end else begin
                    hi = cp;
                    lo = 32'hFFFF_FFFF;
                end
                for (int i = 0; i < 2; i++) begin
                    u_push16(m, (i == 0) ? hi : lo, s);
                end
            end
            usd_pkg::MODE_UTF32LE: begin
                for (int i = 0; i < 4; i++) put_byte(s, cp[8*i +: 8]);
            end
            usd_pkg::MODE_UTF32BE: begin
                for (int i = 3; i >= 0; i--) put_byte(s, cp[8*i +: 8]);
            end
            default: put_byte(s, 8'($urandom_range(0, 255)));
        endcase
    endtask

    initial begin
        t_byte_seq s;
        int len;
        logic [2:0] m;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_mode(usd_pkg::MODE_UTF8);
        push_seq('{8'h00, 8'h7F, 8'hC2, 8'hA2, 8'hE2, 8'h82, 8'hAC, 8'hF0, 8'h9F, 8'h98,
                   8'h80, 8'hC0, 8'h80, 8'hED, 8'hA0, 8'h80, 8'hF4, 8'h90, 8'h80, 8'h80,
                   8'hFF, 8'hC2, 8'h41, 8'hE2, 8'h82}, 1'b1);
        wait_drain();
        write_mode(usd_pkg::MODE_UTF16LE);
        push_seq('{8'h41, 8'h00, 8'h3D, 8'hD8, 8'h00, 8'hDE, 8'h00, 8'hDC, 8'h3D, 8'hD8,
                   8'h41, 8'h00, 8'h3D, 8'hD8}, 1'b1);
        wait_drain();
        write_mode(usd_pkg::MODE_UTF16BE);
        push_seq('{8'hFF, 8'hFF, 8'hD8, 8'h3D, 8'h7F}, 1'b1);
        wait_drain();
        write_mode(usd_pkg::MODE_UTF32LE);
        push_seq('{8'hFF, 8'hFF, 8'h10, 8'h00, 8'h00, 8'h00, 8'h11, 8'h00,
                   8'h00, 8'hD8, 8'h00, 8'h00, 8'h5A}, 1'b1);
        wait_drain();
        write_mode(usd_pkg::MODE_UTF32BE);
        push_seq('{8'h00, 8'h10, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF}, 1'b1);
        wait_drain();
        write_mode(MODE_UNK_HI);
        push_seq('{8'h41, 8'h42}, 1'b1);
        wait_drain();

        while (sent_items < 180) begin
            m = ($urandom_range(0, 9) == 0)
                ? 3'($urandom_range(MODE_UNK_LO, MODE_UNK_HI))
                : 3'($urandom_range(usd_pkg::MODE_UTF8, usd_pkg::MODE_UTF32BE));
            write_mode(m);
            burst = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(1, 3)) begin
                s = {};
                len = $urandom_range(1, 12);
                while (s.size() < len) begin
                    if ($urandom_range(0, 7) == 0) put_byte(s, 8'($urandom_range(0, 255)));
                    else add_char(m, s);
                end
                push_seq(s, $urandom_range(0, 9) != 0);
            end
            wait_drain();
        end
        burst = 1'b0;
        wait_drain();
        if (!failed)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #4000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

>>> filelist.f
rtl/usd_pkg.sv
rtl/usd_datapath.sv
rtl/usd_ctrl.sv
rtl/unicode_stream_decoder_top.sv
sim/tb_unicode_stream_decoder_top.sv
